@@ rtl/ptab_pkg.sv @@
package ptab_pkg;

  localparam int unsigned PAGE_BITS  = 20;
  localparam int unsigned DIR_BITS   = 10;
  localparam int unsigned OFS_BITS   = 12;
  localparam int unsigned CNT_BITS   = 11;
  localparam int unsigned MAX_RUN    = 1024;
  localparam int unsigned DIR_W      = 5;
  localparam int unsigned PTE_W      = 26;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MISALIGNED  = 3'd1;
  localparam logic [2:0] ST_WRONG_SPACE = 3'd2;
  localparam logic [2:0] ST_DIR_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PAGE_ABSENT = 3'd4;
  localparam logic [2:0] ST_MAPPED      = 3'd5;
  localparam logic [2:0] ST_OVERFLOW    = 3'd6;

  // request kinds on the input
  localparam logic [2:0] KIND_MAP   = 3'd0;
  localparam logic [2:0] KIND_UNMAP = 3'd1;
  localparam logic [2:0] KIND_SETF  = 3'd2;
  localparam logic [2:0] KIND_XLATE = 3'd3;
  localparam logic [2:0] KIND_GETF  = 3'd4;

  // internal operations handed to the back end
  localparam logic [2:0] OP_DONE  = 3'd0;
  localparam logic [2:0] OP_MAP   = 3'd1;
  localparam logic [2:0] OP_UNMAP = 3'd2;
  localparam logic [2:0] OP_RUN   = 3'd3;
  localparam logic [2:0] OP_XLATE = 3'd4;
  localparam logic [2:0] OP_GETF  = 3'd5;

  // config register indexes
  localparam logic CFG_KERNEL_START = 1'b0;
  localparam logic CFG_IS_KERNEL    = 1'b1;

  // request flag bits
  localparam int unsigned F_W  = 0;
  localparam int unsigned F_U  = 1;
  localparam int unsigned F_CD = 2;
  localparam int unsigned F_WT = 3;
  localparam int unsigned F_G  = 4;

  // directory entry bits
  localparam int unsigned D_P  = 0;
  localparam int unsigned D_WR = 1;
  localparam int unsigned D_US = 2;
  localparam int unsigned D_CD = 3;
  localparam int unsigned D_WT = 4;

  // page entry bits, frame in [20:1]
  localparam int unsigned P_P  = 0;
  localparam int unsigned P_WR = 21;
  localparam int unsigned P_US = 22;
  localparam int unsigned P_CD = 23;
  localparam int unsigned P_WT = 24;
  localparam int unsigned P_G  = 25;

  typedef struct packed {
    logic [2:0]           op;
    logic [2:0]           status;
    logic [PAGE_BITS-1:0] page;
    logic [OFS_BITS-1:0]  offset;
    logic [PAGE_BITS-1:0] frame;
    logic [CNT_BITS-1:0]  count;
    logic [4:0]           flags;
  } cmd_t;

  function automatic logic space_ok(input logic [31:0] va, input logic [31:0] kstart,
                                    input logic is_kernel);
    space_ok = is_kernel ? (va >= kstart) : (va < kstart);
  endfunction

endpackage

@@ rtl/two_level_page_table_engine_core.sv @@
// Two-level page table engine: a 1024-entry directory and 1M page entries,
// serving map, unmap, set-flags runs, translate and get-flags requests, one
// result item per request item, in order. After reset the tables are swept
// to zero one page entry per cycle, during which s_tready stays low; config
// writes are taken at any time. A single request then passes through the back
// end by queue pop, table read, evaluate and write, and output load; a
// set-flags run repeats the table read and the evaluate-and-write step for
// each further page until one fails. Requests rejected by alignment,
// address-space or run-length checks skip the table read and evaluate steps.
// A two-entry queue decouples request intake from table access.
module two_level_page_table_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // virt_addr[31:0], phys_addr_in[63:32], page_count[74:64], flag_write[75],
  // flag_user[76], flag_cache_disabled[77], flag_write_through[78], flag_global[79]
  input  logic [79:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // phys_addr_out[31:0], out_read[32], out_write[33], out_user[34],
  // out_cache_disabled[35], out_global[36], zeros[39:37]
  output logic [39:0] m_tdata,
  // status[2:0]
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import ptab_pkg::*;

  logic [31:0] kernel_start;
  logic        is_kernel_space;
  cmd_t        f_cmd, q_head;
  logic        q_full, q_avail, q_pop, clearing;
  logic [31:0] out_paddr;
  logic [4:0]  out_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_start    <= 32'hC000_0000;
      is_kernel_space <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KERNEL_START: kernel_start <= cfg_wdata;
        default:          is_kernel_space <= cfg_wdata[0];
      endcase
    end
  end

  assign s_tready = !q_full && !clearing;

  ptab_front u_front (
    .kind            (s_tuser),
    .virt_addr       (s_tdata[31:0]),
    .phys_addr_in    (s_tdata[63:32]),
    .page_count      (s_tdata[74:64]),
    .flags           (s_tdata[79:75]),
    .kernel_start    (kernel_start),
    .is_kernel_space (is_kernel_space),
    .cmd             (f_cmd)
  );

  ptab_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid && s_tready),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  ptab_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_avail         (q_avail),
    .q_cmd           (q_head),
    .q_pop           (q_pop),
    .kernel_start    (kernel_start),
    .is_kernel_space (is_kernel_space),
    .clearing        (clearing),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (m_tuser),
    .out_paddr       (out_paddr),
    .out_flags       (out_flags)
  );

  assign m_tdata = {3'b000, out_flags, out_paddr};

endmodule

@@ rtl/ptab_front.sv @@
module ptab_front (
  input  logic              [2:0]  kind,
  input  logic              [31:0] virt_addr,
  input  logic              [31:0] phys_addr_in,
  input  logic              [10:0] page_count,
  input  logic              [4:0]  flags,
  input  logic              [31:0] kernel_start,
  input  logic                     is_kernel_space,
  output ptab_pkg::cmd_t           cmd
);
  import ptab_pkg::*;

  logic misaligned;

  assign misaligned = (kind != KIND_XLATE) &&
                      ((virt_addr[OFS_BITS-1:0] != '0) ||
                       ((kind == KIND_MAP) && (phys_addr_in[OFS_BITS-1:0] != '0)));

  always_comb begin
    cmd.page   = virt_addr[31:OFS_BITS];
    cmd.offset = virt_addr[OFS_BITS-1:0];
    cmd.frame  = phys_addr_in[31:OFS_BITS];
    cmd.count  = page_count;
    cmd.flags  = flags;
    cmd.op     = OP_DONE;
    cmd.status = ST_OK;
    if (kind > KIND_GETF) begin
      cmd.op = OP_DONE;
    end else if (misaligned) begin
      cmd.status = ST_MISALIGNED;
    end else if (!space_ok(virt_addr, kernel_start, is_kernel_space)) begin
      cmd.status = ST_WRONG_SPACE;
    end else begin
      case (kind)
        KIND_MAP:   cmd.op = OP_MAP;
        KIND_UNMAP: cmd.op = OP_UNMAP;
        KIND_SETF: begin
          if (page_count > CNT_BITS'(MAX_RUN)) begin
            cmd.status = ST_OVERFLOW;
          end else if (page_count != '0) begin
            cmd.op = OP_RUN;
          end
        end
        KIND_XLATE: cmd.op = OP_XLATE;
        default:    cmd.op = OP_GETF;
      endcase
    end
  end

endmodule

@@ rtl/ptab_queue.sv @@
module ptab_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptab_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output ptab_pkg::cmd_t head
);
  import ptab_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/ptab_back.sv @@
module ptab_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_avail,
  input  ptab_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [31:0]    kernel_start,
  input  logic           is_kernel_space,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_status,
  output logic [31:0]    out_paddr,
  output logic [4:0]     out_flags
);
  import ptab_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [DIR_W-1:0] dir_mem [1 << DIR_BITS];
  logic [PTE_W-1:0] pte_mem [1 << PAGE_BITS];

  logic [2:0]           state;
  cmd_t                 cmd;
  logic [PAGE_BITS:0]   run_p;
  logic [CNT_BITS-1:0]  run_i;
  logic [PAGE_BITS-1:0] clr_cnt;
  logic [DIR_W-1:0]     dir_rd;
  logic [PTE_W-1:0]     pte_rd;
  logic [2:0]           res_status;
  logic [31:0]          res_paddr;
  logic [4:0]           res_flags;

  logic [PAGE_BITS-1:0] cur_page;
  logic                 dir_we, pte_we;
  logic [DIR_BITS-1:0]  dir_wa;
  logic [PAGE_BITS-1:0] pte_wa;
  logic [DIR_W-1:0]     dir_wd;
  logic [PTE_W-1:0]     pte_wd;
  logic [2:0]           ev_status;
  logic [31:0]          ev_paddr;
  logic [4:0]           ev_flags;
  logic                 ev_done;
  logic                 out_free;
  logic [DIR_W-1:0]     dir_setf;

  assign cur_page = (cmd.op == OP_RUN) ? run_p[PAGE_BITS-1:0] : cmd.page;
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_avail;
  assign out_free = !out_valid || out_ready;
  assign dir_setf = {cmd.flags[F_WT], cmd.flags[F_CD], cmd.flags[F_U], cmd.flags[F_W], 1'b0};

  always_comb begin
    dir_we    = 1'b0;
    pte_we    = 1'b0;
    dir_wa    = cur_page[PAGE_BITS-1:DIR_BITS];
    pte_wa    = cur_page;
    dir_wd    = dir_rd;
    pte_wd    = pte_rd;
    ev_status = ST_OK;
    ev_paddr  = '0;
    ev_flags  = '0;
    if (state == S_CLEAR) begin
      dir_we = (clr_cnt[PAGE_BITS-1:DIR_BITS] == '0);
      dir_wa = clr_cnt[DIR_BITS-1:0];
      dir_wd = '0;
      pte_we = 1'b1;
      pte_wa = clr_cnt;
      pte_wd = '0;
    end else if (state == S_EV) begin
      case (cmd.op)
        OP_MAP: begin
          if (pte_rd[P_P]) begin
            ev_status = ST_MAPPED;
          end else begin
            dir_we = 1'b1;
            dir_wd = dir_rd | {1'b0, cmd.flags[F_CD], cmd.flags[F_U], cmd.flags[F_W], 1'b1};
            pte_we = 1'b1;
            pte_wd = {cmd.flags[F_G], pte_rd[P_WT], cmd.flags[F_CD], cmd.flags[F_U],
                      cmd.flags[F_W], cmd.frame, 1'b1};
          end
        end
        OP_UNMAP: begin
          if (!dir_rd[D_P]) begin
            ev_status = ST_DIR_ABSENT;
          end else begin
            pte_we = 1'b1;
            pte_wd = {pte_rd[PTE_W-1:1], 1'b0};
          end
        end
        OP_RUN: begin
          if (run_p[PAGE_BITS]) begin
            ev_status = ST_OVERFLOW;
          end else if (!space_ok({run_p[PAGE_BITS-1:0], {OFS_BITS{1'b0}}},
                                 kernel_start, is_kernel_space)) begin
            ev_status = ST_WRONG_SPACE;
          end else if (!dir_rd[D_P]) begin
            ev_status = ST_DIR_ABSENT;
          end else if (!pte_rd[P_P]) begin
            ev_status = ST_PAGE_ABSENT;
          end else begin
            dir_we = 1'b1;
            dir_wd = dir_rd | dir_setf;
            pte_we = 1'b1;
            pte_wd = {cmd.flags[F_G], cmd.flags[F_WT], cmd.flags[F_CD], cmd.flags[F_U],
                      cmd.flags[F_W], pte_rd[PAGE_BITS:0]};
          end
        end
        OP_XLATE, OP_GETF: begin
          if (!dir_rd[D_P]) begin
            ev_status = ST_DIR_ABSENT;
          end else if (!pte_rd[P_P]) begin
            ev_status = ST_PAGE_ABSENT;
          end else if (cmd.op == OP_XLATE) begin
            ev_paddr = {pte_rd[PAGE_BITS:1], cmd.offset};
          end else begin
            // read, write, user, cache-disabled, global from the low bit up
            ev_flags = {pte_rd[P_G], dir_rd[D_CD] & pte_rd[P_CD],
                        dir_rd[D_US] & pte_rd[P_US], dir_rd[D_WR] & pte_rd[P_WR], 1'b1};
          end
        end
        default: ev_status = cmd.status;
      endcase
    end
  end

  assign ev_done = (cmd.op != OP_RUN) || (ev_status != ST_OK) ||
                   ((run_i + 1'b1) == cmd.count);

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (state == S_RD) dir_rd <= dir_mem[cur_page[PAGE_BITS-1:DIR_BITS]];
  end

  always_ff @(posedge clk) begin
    if (pte_we) pte_mem[pte_wa] <= pte_wd;
    if (state == S_RD) pte_rd <= pte_mem[cur_page];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken item unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_avail) begin
            cmd        <= q_cmd;
            run_p      <= {1'b0, q_cmd.page};
            run_i      <= '0;
            res_status <= q_cmd.status;
            res_paddr  <= '0;
            res_flags  <= '0;
            state      <= (q_cmd.op == OP_DONE) ? S_OUT : S_RD;
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          if (ev_done) begin
            res_status <= ev_status;
            res_paddr  <= ev_paddr;
            res_flags  <= ev_flags;
            state      <= S_OUT;
          end else begin
            run_p <= run_p + 1'b1;
            run_i <= run_i + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_paddr  <= res_paddr;
            out_flags  <= res_flags;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_pte_write_phase: assert property (@(posedge clk) disable iff (rst)
    pte_we |-> (state == S_EV || state == S_CLEAR))
    else $error("page entry written outside evaluate or clear");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV && cmd.op == OP_RUN) |-> (run_i < cmd.count))
    else $error("run index passed page count");

  a_out_only_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

endmodule

@@ dv/two_level_page_table_engine_core_tb.sv @@
module two_level_page_table_engine_core_tb;
  import ptab_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] va;
    logic [31:0] pa;
    logic [10:0] cnt;
    logic [4:0]  flags;
    bit          typed;
    logic [2:0]  st;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] paddr;
    logic        rd, wr, us, cd, gl;
  } resp_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [79:0] s_tdata;
  logic [2:0]  s_tuser, m_tuser;
  logic [39:0] m_tdata;
  logic        cfg_we, cfg_addr;
  logic [31:0] cfg_wdata;

  logic [4:0]  dir_model [1024];
  logic [25:0] pte_model [int unsigned];
  logic [31:0] kstart_m;
  logic        kspace_m;

  resp_t       pending_q[$];
  req_t        directed_rows[$];
  int          errs;
  bit          quiet;
  int          stall_left;

  two_level_page_table_engine_core u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("** two_level_page_table_engine_core: FAILED **");
    $finish;
  end

  function automatic bit in_space(logic [31:0] va);
    return kspace_m ? (va >= kstart_m) : (va < kstart_m);
  endfunction

  function automatic logic [25:0] pte_rd(int unsigned pg);
    return pte_model.exists(pg) ? pte_model[pg] : 26'd0;
  endfunction

  // apply one request to the table copy and return its result
  function automatic resp_t walk_table(req_t r);
    resp_t       o;
    int unsigned pg, p;
    logic [9:0]  dd;
    logic [25:0] e;
    logic [4:0]  de;
    o = '{default: '0};
    pg = 32'(r.va[31:12]);
    dd = r.va[31:22];
    if (r.kind > KIND_GETF) begin
      // ignore
    end else if (r.kind != KIND_XLATE &&
                 (r.va[11:0] != 0 || (r.kind == KIND_MAP && r.pa[11:0] != 0))) begin
      o.status = ST_MISALIGNED;
    end else if (!in_space(r.va)) begin
      o.status = ST_WRONG_SPACE;
    end else if (r.kind == KIND_MAP) begin
      e = pte_rd(pg);
      if (e[P_P]) begin
        o.status = ST_MAPPED;
      end else begin
        dir_model[dd][D_P] = 1'b1;
        dir_model[dd][D_WR] |= r.flags[F_W];
        dir_model[dd][D_US] |= r.flags[F_U];
        dir_model[dd][D_CD] |= r.flags[F_CD];
        e[P_P] = 1'b1;
        e[20:1] = r.pa[31:12];
        e[P_WR] = r.flags[F_W];
        e[P_US] = r.flags[F_U];
        e[P_CD] = r.flags[F_CD];
        e[P_G] = r.flags[F_G];
        pte_model[pg] = e;
      end
    end else if (r.kind == KIND_UNMAP) begin
      if (!dir_model[dd][D_P]) o.status = ST_DIR_ABSENT;
      else begin
        e = pte_rd(pg);
        e[P_P] = 1'b0;
        pte_model[pg] = e;
      end
    end else if (r.kind == KIND_SETF) begin
      if (r.cnt > MAX_RUN) o.status = ST_OVERFLOW;
      else begin
        for (int i = 0; i < r.cnt; i++) begin
          p = pg + i;
          if (p >= 32'h100000) begin o.status = ST_OVERFLOW; break; end
          if (!in_space({p[19:0], 12'h000})) begin o.status = ST_WRONG_SPACE; break; end
          if (!dir_model[p[19:10]][D_P]) begin o.status = ST_DIR_ABSENT; break; end
          e = pte_rd(p);
          if (!e[P_P]) begin o.status = ST_PAGE_ABSENT; break; end
          dir_model[p[19:10]][D_WR] |= r.flags[F_W];
          dir_model[p[19:10]][D_US] |= r.flags[F_U];
          dir_model[p[19:10]][D_CD] |= r.flags[F_CD];
          dir_model[p[19:10]][D_WT] |= r.flags[F_WT];
          e[P_WR] = r.flags[F_W];
          e[P_US] = r.flags[F_U];
          e[P_CD] = r.flags[F_CD];
          e[P_WT] = r.flags[F_WT];
          e[P_G] = r.flags[F_G];
          pte_model[p] = e;
        end
      end
    end else begin
      de = dir_model[dd];
      e = pte_rd(pg);
      if (!de[D_P]) o.status = ST_DIR_ABSENT;
      else if (!e[P_P]) o.status = ST_PAGE_ABSENT;
      else if (r.kind == KIND_XLATE) o.paddr = {e[20:1], r.va[11:0]};
      else begin
        o.rd = 1'b1;
        o.wr = de[D_WR] & e[P_WR];
        o.us = de[D_US] & e[P_US];
        o.cd = de[D_CD] & e[P_CD];
        o.gl = e[P_G];
      end
    end
    return o;
  endfunction

  task automatic send_req(req_t r);
    resp_t o;
    int    gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {r.flags, r.cnt, r.pa, r.va};
    do @(posedge clk); while (!s_tready);
    o = walk_table(r);
    if (r.typed) o = '{status: r.st, default: '0};
    pending_q.push_back(o);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KERNEL_START) kstart_m = val;
    else kspace_m = val[0];
  endtask

  task automatic add_row(logic [2:0] k, logic [31:0] va, logic [31:0] pa, logic [10:0] c,
                         logic [4:0] f, bit typed, logic [2:0] st);
    directed_rows.push_back('{k, va, pa, c, f, typed, st});
  endtask

  // pick a page mostly near one of a few hot spots so requests keep hitting mapped entries
  function automatic req_t rand_req();
    req_t        r;
    logic [19:0] base;
    int          sel;
    sel = $urandom_range(0, 99);
    r.typed = 0;
    r.st = ST_OK;
    if (sel < 28) r.kind = KIND_MAP;
    else if (sel < 38) r.kind = KIND_UNMAP;
    else if (sel < 54) r.kind = KIND_SETF;
    else if (sel < 74) r.kind = KIND_XLATE;
    else if (sel < 95) r.kind = KIND_GETF;
    else r.kind = 3'($urandom_range(5, 7));
    case ($urandom_range(0, 4))
      0: base = 20'h00000;
      1: base = kstart_m[31:12] - 20'd4;
      2: base = 20'hFFFF8;
      3: base = 20'h003FC;
      default: base = 20'($urandom);
    endcase
    r.va = {base + 20'($urandom_range(0, 7)), 12'h000};
    if ($urandom_range(0, 9) == 0) r.va = $urandom;
    if (r.kind == KIND_XLATE || $urandom_range(0, 9) == 0) r.va[11:0] = 12'($urandom);
    r.pa = {$urandom_range(0, 32'hFFFFF) << 12};
    if ($urandom_range(0, 19) == 0) r.pa = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 3) r.cnt = 11'($urandom_range(1025, 2047));
    else if (sel < 5) r.cnt = 11'($urandom_range(512, 1024));
    else r.cnt = 11'($urandom_range(0, 6));
    r.flags = 5'($urandom);
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t ex;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing expected: status %0d", m_tuser);
          errs++;
        end else begin
          ex = pending_q.pop_front();
          if (m_tuser !== ex.status) begin
            $error("status: expected %0d, got %0d", ex.status, m_tuser); errs++;
          end
          if (m_tdata[31:0] !== ex.paddr) begin
            $error("phys_addr_out: expected %h, got %h", ex.paddr, m_tdata[31:0]); errs++;
          end
          if (m_tdata[32] !== ex.rd) begin
            $error("out_read: expected %b, got %b", ex.rd, m_tdata[32]); errs++;
          end
          if (m_tdata[33] !== ex.wr) begin
            $error("out_write: expected %b, got %b", ex.wr, m_tdata[33]); errs++;
          end
          if (m_tdata[34] !== ex.us) begin
            $error("out_user: expected %b, got %b", ex.us, m_tdata[34]); errs++;
          end
          if (m_tdata[35] !== ex.cd) begin
            $error("out_cache_disabled: expected %b, got %b", ex.cd, m_tdata[35]); errs++;
          end
          if (m_tdata[36] !== ex.gl) begin
            $error("out_global: expected %b, got %b", ex.gl, m_tdata[36]); errs++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] ks_set [5] = '{32'hC000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_F000,
                                32'hFFFF_F000};
    logic        kk_set [5] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    errs = 0;
    quiet = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_wdata = '0;
    dir_model = '{default: '0};
    kstart_m = 32'hC000_0000;
    kspace_m = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(KIND_XLATE, 32'h0000_1234, 0, 0, 0, 1, ST_DIR_ABSENT);
    add_row(KIND_MAP, 32'h0000_1001, 0, 0, 0, 1, ST_MISALIGNED);
    add_row(KIND_MAP, 32'h0000_1000, 32'h2001, 0, 0, 1, ST_MISALIGNED);
    add_row(KIND_MAP, 32'hC000_0000, 0, 0, 0, 1, ST_WRONG_SPACE);
    add_row(KIND_UNMAP, 32'h0000_5000, 0, 0, 0, 1, ST_DIR_ABSENT);
    add_row(KIND_SETF, 32'h0, 0, 11'd1025, 0, 1, ST_OVERFLOW);
    add_row(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF, 5'h1F, 1, ST_OK);
    add_row(3'd7, 32'h0, 0, 0, 0, 1, ST_OK);
    add_row(KIND_MAP, 32'h0, 32'hFFFF_F000, 0, 5'h1F, 0, ST_OK);
    add_row(KIND_MAP, 32'h0, 32'h0, 0, 0, 1, ST_MAPPED);
    add_row(KIND_XLATE, 32'h0000_0FFF, 0, 0, 0, 0, ST_OK);
    add_row(KIND_GETF, 32'h0, 0, 0, 0, 0, ST_OK);
    add_row(KIND_MAP, 32'hBFFF_F000, 32'h0, 0, 0, 0, ST_OK);
    add_row(KIND_GETF, 32'h0000_1000, 0, 0, 0, 1, ST_PAGE_ABSENT);
    add_row(KIND_SETF, 32'h0, 0, 11'd2, 5'h08, 0, ST_OK);
    add_row(KIND_MAP, 32'h0000_1000, 32'h1234_5000, 0, 5'h01, 0, ST_OK);
    add_row(KIND_SETF, 32'h0, 0, 11'd2, 5'h1A, 0, ST_OK);
    add_row(KIND_SETF, 32'hBFFF_F000, 0, 11'd2, 5'h07, 0, ST_OK);
    add_row(KIND_SETF, 32'h0000_7000, 0, 11'd0, 0, 0, ST_OK);
    add_row(KIND_UNMAP, 32'h0000_1000, 0, 0, 0, 0, ST_OK);
    add_row(KIND_UNMAP, 32'h0000_1000, 0, 0, 0, 0, ST_OK);
    add_row(KIND_XLATE, 32'h0000_1ABC, 0, 0, 0, 0, ST_OK);
    add_row(KIND_GETF, 32'h0000_3004, 0, 0, 0, 1, ST_MISALIGNED);
    add_row(KIND_XLATE, 32'hBFFF_FABC, 0, 0, 0, 0, ST_OK);

    for (int ph = 0; ph < 5; ph++) begin
      if (s_tvalid) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      write_cfg(CFG_KERNEL_START, ks_set[ph]);
      write_cfg(CFG_IS_KERNEL, {31'd0, kk_set[ph]});
      if (ph == 0) foreach (directed_rows[i]) send_req(directed_rows[i]);
      if (ph == 4) begin
        // top of the address space: map the two pages just below the kernel start
        send_req('{KIND_MAP, 32'hFFFF_E000, 32'h5000, 0, 5'h1F, 0, ST_OK});
        send_req('{KIND_MAP, 32'hFFFF_D000, 32'h6000, 0, 5'h00, 0, ST_OK});
      end
      for (int n = 0; n < 130; n++) begin
        if (ph == 4 && n == 60) quiet = 1;
        send_req(rand_req());
      end
    end
    s_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errs == 0)
      $display("** two_level_page_table_engine_core: PASSED **");
    else
      $display("** two_level_page_table_engine_core: FAILED **");
    $finish;
  end

endmodule
